// ===== hw/rtl/overwrite_ring_queue_average_core_macros.svh =====
// Assertion macros for the overwrite ring queue average core.
// Depends on nothing; included by the files that carry assertions.
`ifndef OVERWRITE_RING_QUEUE_AVERAGE_CORE_MACROS_SVH
`define OVERWRITE_RING_QUEUE_AVERAGE_CORE_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define ORQA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define ORQA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ORQA_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define ORQA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/orqa_pkg.sv =====
// Shared types and constants of the overwrite ring queue average core.
// Depends on nothing; imported by orqa_div and the top level.
package orqa_pkg;

   localparam int ID_W     = 12;
   localparam int HEIGHT_W = 8;
   localparam int COUNT_W  = 3;
   localparam int QUOT_W   = 8;
   localparam int STEP_W   = $clog2(QUOT_W);

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_DIVIDE
   } state_type;

   typedef struct packed {
      logic [ID_W-1:0]     id;
      logic [HEIGHT_W-1:0] height;
   } slot_type;

   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ===== hw/rtl/orqa_div.sv =====
// Bit-serial restoring divider for the rounded mean: (2*sum+count)/(2*count).
// Depends on orqa_pkg.
module orqa_div
   import orqa_pkg::*;
#(
   parameter int SUM_W = 11,
   parameter int CNT_W = 3
) (
   input  logic               clock,
   input  logic               reset,
   input  div_ctrl_type       ctrl,
   input  logic [SUM_W-1:0]   sum_val,
   input  logic [CNT_W-1:0]   count_val,
   output div_stat_type       stat,
   output logic [QUOT_W-1:0]  quotient
);

   localparam int DW = CNT_W + 1;
   localparam int RA = SUM_W + 2;
   localparam int RB = DW + QUOT_W;
   localparam int W  = (RA > RB) ? RA : RB;

   logic [W-1:0]      rem_ff, rem_in;
   logic [DW-1:0]     den_ff, den_in;
   logic [QUOT_W-1:0] q_ff, q_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              zero_ff, zero_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [W-1:0]      trial;

   assign trial = W'(den_ff) << step_ff;

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      step_in = step_ff;
      zero_in = zero_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (ctrl.start) begin
         rem_in  = W'({sum_val, 1'b0}) + W'(count_val);
         den_in  = {count_val, 1'b0};
         zero_in = (count_val == '0);
         q_in    = '0;
         step_in = '1;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         // subtract where the shifted divisor fits
         if (rem_ff >= trial) begin
            rem_in        = rem_ff - trial;
            q_in[step_ff] = 1'b1;
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      q_ff    <= q_in;
      step_ff <= step_in;
      zero_ff <= zero_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = zero_ff ? '0 : q_ff;

endmodule

// ===== hw/rtl/overwrite_ring_queue_average_core.sv =====
// Ring queue of DEPTH entries {id, height} that drops its oldest entry when an insert
// finds it full. Opcode insert appends; opcode remove pops and returns the oldest entry,
// or flags empty_error and leaves the queue alone when there is nothing to pop. Every
// transaction returns one response with the entry count after the operation and the mean
// height of the queued entries rounded half up (0 when empty). One transaction is in
// flight at a time: the head slot is read from the synchronous slot memory at the
// accepting edge, the fetch state updates the ring and the running height sum and starts
// the divider, eight steps of the bit-serial restoring divider produce the mean and the
// response register is then loaded. The block returns to idle before the next request
// is taken, so a new request waits until the divider is through with the last one; a
// stalled response holds the block until the response register frees. The response
// register lets the next request be taken while a finished response still waits.
// Depends on orqa_pkg, orqa_div and overwrite_ring_queue_average_core_macros.svh.
`include "overwrite_ring_queue_average_core_macros.svh"

module overwrite_ring_queue_average_core
   import orqa_pkg::*;
#(
   parameter int DEPTH = 5
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_opcode,
   input  logic [ID_W-1:0]     req_entry_id,
   input  logic [HEIGHT_W-1:0] req_entry_height,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_removed_valid,
   output logic [ID_W-1:0]     rsp_removed_id,
   output logic [HEIGHT_W-1:0] rsp_removed_height,
   output logic                rsp_empty_error,
   output logic [COUNT_W-1:0]  rsp_entry_count,
   output logic [QUOT_W-1:0]   rsp_mean_height
);

   // one spare slot keeps head and tail apart when the queue is full
   localparam int SLOTS = DEPTH + 1;
   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS);
   localparam int SUM_W = HEIGHT_W + CNT_W;

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
      ring_next = (idx == IDX_W'(DEPTH)) ? '0 : idx + 1'b1;
   endfunction

   // control
   state_type state_ff, state_in;
   logic      accept;
   logic      fetch_en;
   logic      out_free;
   logic      out_load;

   // captured request
   opcode_type          op_ff, op_in;
   logic [ID_W-1:0]     id_ff, id_in;
   logic [HEIGHT_W-1:0] height_ff, height_in;

   // ring state
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] occ_ff, occ_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic             full;
   logic             empty;

   // slot memory
   slot_type slot_mem [SLOTS];
   slot_type rd_data_ff;
   slot_type wr_data;
   logic     mem_we;

   // pending result fields
   logic                res_valid_ff, res_valid_in;
   logic [ID_W-1:0]     res_id_ff, res_id_in;
   logic [HEIGHT_W-1:0] res_height_ff, res_height_in;
   logic                res_err_ff, res_err_in;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_removed_valid_ff, rsp_removed_valid_in;
   logic [ID_W-1:0]     rsp_removed_id_ff, rsp_removed_id_in;
   logic [HEIGHT_W-1:0] rsp_removed_height_ff, rsp_removed_height_in;
   logic                rsp_empty_error_ff, rsp_empty_error_in;
   logic [COUNT_W-1:0]  rsp_entry_count_ff, rsp_entry_count_in;
   logic [QUOT_W-1:0]   rsp_mean_height_ff, rsp_mean_height_in;
   logic [CNT_W+COUNT_W-1:0] occ_ext;

   // divider
   div_ctrl_type      div_ctrl;
   div_stat_type      div_stat;
   logic [QUOT_W-1:0] div_quot;

   assign full     = (occ_ff == CNT_W'(DEPTH));
   assign empty    = (occ_ff == '0);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign accept   = req_valid && req_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_FETCH;
         end
         ST_FETCH: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            // leave once the mean is ready and the response register is free
            if (div_stat.done && out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_ready      = 1'b0;
      fetch_en       = 1'b0;
      div_ctrl.start = 1'b0;
      out_load       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_FETCH: begin
            fetch_en       = 1'b1;
            div_ctrl.start = 1'b1;
         end
         ST_DIVIDE: begin
            out_load = div_stat.done && out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // capture the transaction; the head slot is read in the same cycle
   always_comb begin
      op_in     = op_ff;
      id_in     = id_ff;
      height_in = height_ff;
      if (accept) begin
         op_in     = opcode_type'(req_opcode);
         id_in     = req_entry_id;
         height_in = req_entry_height;
      end
   end

   // ring update, in the cycle after acceptance when the head slot data is back
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      occ_in        = occ_ff;
      sum_in        = sum_ff;
      mem_we        = 1'b0;
      res_valid_in  = res_valid_ff;
      res_id_in     = res_id_ff;
      res_height_in = res_height_ff;
      res_err_in    = res_err_ff;
      if (fetch_en) begin
         res_valid_in  = 1'b0;
         res_id_in     = '0;
         res_height_in = '0;
         res_err_in    = 1'b0;
         case (op_ff)
            OP_INSERT: begin
               mem_we  = 1'b1;
               tail_in = ring_next(tail_ff);
               if (full) begin
                  // drop the oldest entry silently, count stays at DEPTH
                  head_in = ring_next(head_ff);
                  sum_in  = sum_ff - SUM_W'(rd_data_ff.height) + SUM_W'(height_ff);
               end else begin
                  occ_in = occ_ff + 1'b1;
                  sum_in = sum_ff + SUM_W'(height_ff);
               end
            end
            OP_REMOVE: begin
               if (empty) begin
                  res_err_in = 1'b1;
               end else begin
                  res_valid_in  = 1'b1;
                  res_id_in     = rd_data_ff.id;
                  res_height_in = rd_data_ff.height;
                  head_in       = ring_next(head_ff);
                  occ_in        = occ_ff - 1'b1;
                  sum_in        = sum_ff - SUM_W'(rd_data_ff.height);
               end
            end
            default: begin
               mem_we = 1'b0;
            end
         endcase
      end
   end

   assign wr_data.id     = id_ff;
   assign wr_data.height = height_ff;

   // slot memory: one write port at the tail, one registered read port at the head
   always_ff @(posedge clock) begin
      if (mem_we) slot_mem[tail_ff] <= wr_data;
      rd_data_ff <= slot_mem[head_ff];
   end

   orqa_div #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (div_ctrl),
      .sum_val   (sum_in),
      .count_val (occ_in),
      .stat      (div_stat),
      .quotient  (div_quot)
   );

   // response register
   assign occ_ext = {{COUNT_W{1'b0}}, occ_ff};

   always_comb begin
      rsp_valid_in          = rsp_valid_ff;
      rsp_removed_valid_in  = rsp_removed_valid_ff;
      rsp_removed_id_in     = rsp_removed_id_ff;
      rsp_removed_height_in = rsp_removed_height_ff;
      rsp_empty_error_in    = rsp_empty_error_ff;
      rsp_entry_count_in    = rsp_entry_count_ff;
      rsp_mean_height_in    = rsp_mean_height_ff;
      if (out_load) begin
         rsp_valid_in          = 1'b1;
         rsp_removed_valid_in  = res_valid_ff;
         rsp_removed_id_in     = res_id_ff;
         rsp_removed_height_in = res_height_ff;
         rsp_empty_error_in    = res_err_ff;
         rsp_entry_count_in    = occ_ext[COUNT_W-1:0];
         rsp_mean_height_in    = div_quot;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff                 <= op_in;
      id_ff                 <= id_in;
      height_ff             <= height_in;
      res_valid_ff          <= res_valid_in;
      res_id_ff             <= res_id_in;
      res_height_ff         <= res_height_in;
      res_err_ff            <= res_err_in;
      rsp_removed_valid_ff  <= rsp_removed_valid_in;
      rsp_removed_id_ff     <= rsp_removed_id_in;
      rsp_removed_height_ff <= rsp_removed_height_in;
      rsp_empty_error_ff    <= rsp_empty_error_in;
      rsp_entry_count_ff    <= rsp_entry_count_in;
      rsp_mean_height_ff    <= rsp_mean_height_in;
   end

   // control and ring state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_removed_valid  = rsp_removed_valid_ff;
   assign rsp_removed_id     = rsp_removed_id_ff;
   assign rsp_removed_height = rsp_removed_height_ff;
   assign rsp_empty_error    = rsp_empty_error_ff;
   assign rsp_entry_count    = rsp_entry_count_ff;
   assign rsp_mean_height    = rsp_mean_height_ff;

   `ORQA_ASSERT_IMPL(a_occ_bound, clock, reset, 1'b1, occ_ff <= CNT_W'(DEPTH),
      "occupancy above DEPTH")
   `ORQA_ASSERT_IMPL(a_empty_sum, clock, reset, occ_ff == '0, sum_ff == '0,
      "height sum nonzero on empty queue")
   `ORQA_ASSERT_NEXT(a_fetch_div, clock, reset, state_ff == ST_FETCH,
      state_ff == ST_DIVIDE && div_stat.busy, "divider not started after fetch")
   `ORQA_ASSERT_IMPL(a_rsp_excl, clock, reset, rsp_valid_ff,
      !(rsp_removed_valid_ff && rsp_empty_error_ff), "removed entry and empty error together")

endmodule
